>>> rtl/http_message_length_framer_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the HTTP message length framer.
// Each macro expands to one labelled concurrent assertion on the rising edge
// of the given clock, disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef HTTP_MESSAGE_LENGTH_FRAMER_TOP_MACROS_SVH
`define HTTP_MESSAGE_LENGTH_FRAMER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HMLF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HMLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hmlf_pkg.sv
// ---------------------------------------------------------------------------
// hmlf_pkg
// Shared types, codes and constants of the HTTP message length framer.
// ---------------------------------------------------------------------------
`default_nettype none

package hmlf_pkg;

  // Default width of the saturating byte counters.
  localparam int COUNT_WIDTH_DEFAULT = 34;

  // Configuration register indexes and reset values.
  localparam logic CFG_MAX_BODY   = 1'b0;
  localparam logic CFG_MAX_HEADER = 1'b1;
  localparam logic [31:0] MAX_BODY_RESET   = 32'd268435456;
  localparam logic [20:0] MAX_HEADER_RESET = 21'd32768;

  // Message phases.
  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_HDR_NONE = 3'd1;
  localparam logic [2:0] PH_HDR      = 3'd2;
  localparam logic [2:0] PH_BODY     = 3'd3;
  localparam logic [2:0] PH_DONE     = 3'd4;

  // Position within a header line.
  localparam logic [1:0] LF_NAME   = 2'd0;
  localparam logic [1:0] LF_LENGTH = 2'd1;
  localparam logic [1:0] LF_SKIP   = 2'd2;

  // Result status codes.
  localparam logic [3:0] ST_HEADER       = 4'd0;
  localparam logic [3:0] ST_BODY         = 4'd1;
  localparam logic [3:0] ST_COMPLETE     = 4'd2;
  localparam logic [3:0] ST_BAD_START    = 4'd3;
  localparam logic [3:0] ST_BAD_LINE     = 4'd4;
  localparam logic [3:0] ST_DUP_LENGTH   = 4'd5;
  localparam logic [3:0] ST_BAD_VALUE    = 4'd6;
  localparam logic [3:0] ST_BODY_BIG     = 4'd7;
  localparam logic [3:0] ST_HEADER_BIG   = 4'd8;
  localparam logic [3:0] ST_MESSAGE_BIG  = 4'd9;
  localparam logic [3:0] ST_INCOMPLETE   = 4'd10;
  localparam logic [3:0] ST_EXTRA_BYTES  = 4'd11;
  localparam logic [3:0] ST_CLOSED_EARLY = 4'd12;
  localparam logic [3:0] ERR_NONE        = 4'd0;

  // Characters of interest.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Header name that carries the body length, in lower case.
  localparam int NAME_LEN = 14;
  localparam logic [8*NAME_LEN-1:0] LENGTH_NAME = "content-length";

  // Largest accumulator value that may still take another decimal digit.
  localparam logic [63:0] ACC_LIMIT = 64'd1844674407370955161;

  // Saturation limits of the output fields.
  localparam logic [63:0] DECL_MAX   = 64'hFFFF_FFFF;
  localparam logic [63:0] OFFSET_MAX = 64'h1F_FFFF;

  // Parse state of the current header line.
  typedef struct packed {
    logic [1:0]  field;
    logic [3:0]  name_idx;
    logic        name_mismatch;
    logic [63:0] acc;
    logic        digit_seen;
    logic        trailing;
  } line_t;

  localparam line_t LINE_CLEAR = '{field: LF_NAME, name_idx: 4'd0,
                                   name_mismatch: 1'b0, acc: 64'd0,
                                   digit_seen: 1'b0, trailing: 1'b0};

  // Outcome of feeding one character into the line parser.
  typedef struct packed {
    line_t      line;
    logic [3:0] err;
  } feed_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  status;
    logic        body_byte;
    logic [31:0] content_len;
    logic [20:0] body_offset;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/hmlf_out_reg.sv
// ---------------------------------------------------------------------------
// hmlf_out_reg
// Result register between the framer logic and the result channel. It holds
// a result while the receiver stalls and frees the slot as it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module hmlf_out_reg
  import hmlf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic    valid_r;
  result_t data_r;

  // A new result may enter when the slot is empty or is taken this cycle.
  assign full_stall = valid_r && out_stall;

  // Slot occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

>>> rtl/http_message_length_framer_top.sv
// ---------------------------------------------------------------------------
// http_message_length_framer_top
// Byte-wise HTTP/1.1 header scanner and Content-Length body framer.
// ---------------------------------------------------------------------------
// Usage:
// One message byte (or a close marker) enters on the in_ channel per
// transfer; in_new_message clears all parse state before that item is
// handled. Every input item gives exactly one result on the out_ channel:
// a status code, a body flag, the declared length and the body offset.
// The two size limits are written on the cfg_ port while the block is idle.
// The result of an accepted item is registered and shown on out_valid in the
// next cycle. Without a stall, throughput is one item per cycle; all
// per-byte work (terminator match, name compare, times-ten accumulate,
// limit compares) sits between the parse state registers and the result
// register. When the receiver stalls, the result register holds its item and
// in_stall rises, so at most one result waits and no item is dropped.
// Synchronous reset empties the result register, restores both limits to
// their defaults and returns the parser to the start line of a new message.
// ---------------------------------------------------------------------------
`default_nettype none

`include "http_message_length_framer_top_macros.svh"

module http_message_length_framer_top
  import hmlf_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_closed,
  input  wire logic        in_new_message,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_status,
  output logic             out_body_byte,
  output logic [31:0]      out_content_len,
  output logic [20:0]      out_body_offset,
  // Configuration port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int CMP_W = (COUNT_WIDTH > 33) ? COUNT_WIDTH : 33;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Feed one character into the header line parser.
  function automatic feed_t feed(input line_t ln, input logic at_start,
                                 input logic seen, input logic [7:0] c);
    feed_t      r;
    logic [7:0] lc;
    logic [7:0] nc;
    logic [63:0] d;
    r.line = ln;
    r.err  = ERR_NONE;
    lc = ((c >= 8'h41) && (c <= 8'h5A)) ? 8'(c + 8'd32) : c;
    nc = (ln.name_idx < 4'(NAME_LEN)) ?
         LENGTH_NAME[8*(NAME_LEN-1-int'(ln.name_idx)) +: 8] : 8'd0;
    d  = 64'(c - 8'h30);
    if (!at_start) begin
      case (ln.field)
        LF_NAME: begin
          if (c == CH_COLON) begin
            if (!ln.name_mismatch && (ln.name_idx == 4'(NAME_LEN))) begin
              if (seen) begin
                r.err        = ST_DUP_LENGTH;
                r.line.field = LF_SKIP;
              end else begin
                r.line.field      = LF_LENGTH;
                r.line.acc        = 64'd0;
                r.line.digit_seen = 1'b0;
                r.line.trailing   = 1'b0;
              end
            end else begin
              r.line.field = LF_SKIP;
            end
          end else if (!ln.name_mismatch && (ln.name_idx < 4'(NAME_LEN)) && (lc == nc)) begin
            r.line.name_idx = ln.name_idx + 4'd1;
          end else begin
            r.line.name_mismatch = 1'b1;
          end
        end
        LF_LENGTH: begin
          if ((c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13))) begin
            if (ln.digit_seen) begin
              r.line.trailing = 1'b1;
            end
          end else if ((c >= 8'h30) && (c <= 8'h39) && !ln.trailing) begin
            if ((ln.acc > ACC_LIMIT) || ((ln.acc == ACC_LIMIT) && (d > 64'd5))) begin
              r.err        = ST_BAD_VALUE;
              r.line.field = LF_SKIP;
            end else begin
              r.line.acc = {ln.acc[60:0], 3'b000} + {ln.acc[62:0], 1'b0} + d;
              r.line.digit_seen = 1'b1;
            end
          end else begin
            r.err        = ST_BAD_VALUE;
            r.line.field = LF_SKIP;
          end
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  // Configuration registers.
  logic [31:0] max_body_r;
  logic [20:0] max_header_r;

  // Parse state.
  logic [2:0]             phase_r, phase_nxt;
  logic [1:0]             term_r, term_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  line_t                  line_r, line_nxt;
  logic                   seen_r, seen_nxt;
  logic [63:0]            length_r, length_nxt;
  logic [3:0]             perr_r, perr_nxt;
  logic [COUNT_WIDTH-1:0] expect_r, expect_nxt;
  logic [3:0]             sticky_r, sticky_nxt;
  logic [COUNT_WIDTH-1:0] bstart_r, bstart_nxt;

  logic    accept;
  logic    full_stall;
  result_t res;
  result_t out_data;

  assign accept   = in_valid && !full_stall;
  assign in_stall = full_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r   <= MAX_BODY_RESET;
      max_header_r <= MAX_HEADER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_BODY:   max_body_r   <= cfg_wdata;
        CFG_MAX_HEADER: max_header_r <= cfg_wdata[20:0];
        default: begin
        end
      endcase
    end
  end

  // Per-item parse step.
  always_comb begin
    logic [2:0]             ph;
    logic [1:0]             tm;
    logic [COUNT_WIDTH-1:0] bc;
    line_t                  ln;
    logic                   at_start;
    logic                   pend;
    logic                   found;
    feed_t                  fr;
    logic [64:0]            esum;
    logic [CMP_W-1:0]       limit;
    logic [3:0]             st;
    logic                   body;

    // A new message starts from the cleared state.
    ph  = in_new_message ? PH_START : phase_r;
    tm  = in_new_message ? 2'd0 : term_r;
    bc  = in_new_message ? '0 : count_r;
    ln  = in_new_message ? LINE_CLEAR : line_r;
    phase_nxt  = ph;
    term_nxt   = tm;
    line_nxt   = ln;
    seen_nxt   = in_new_message ? 1'b0 : seen_r;
    length_nxt = in_new_message ? 64'd0 : length_r;
    perr_nxt   = in_new_message ? ERR_NONE : perr_r;
    expect_nxt = in_new_message ? '0 : expect_r;
    sticky_nxt = in_new_message ? ST_HEADER : sticky_r;
    bstart_nxt = in_new_message ? '0 : bstart_r;
    count_nxt  = bc;

    at_start = (ph == PH_START);
    pend     = (tm == 2'd1) || (tm == 2'd3);
    found    = 1'b0;
    fr       = '0;
    esum     = '0;
    st       = ST_HEADER;
    body     = 1'b0;
    limit    = CMP_W'(max_body_r) + CMP_W'(max_header_r);

    if (ph == PH_DONE) begin
      // Finished messages repeat their status; a byte after completion is extra.
      if ((sticky_nxt == ST_COMPLETE) && !in_closed) begin
        sticky_nxt = ST_EXTRA_BYTES;
      end
      st = sticky_nxt;
    end else if (in_closed) begin
      st         = (ph == PH_BODY) ? ST_INCOMPLETE : ST_CLOSED_EARLY;
      phase_nxt  = PH_DONE;
      sticky_nxt = st;
    end else begin
      count_nxt = (bc != COUNT_MAX) ? bc + 1'b1 : bc;
      if (CMP_W'(count_nxt) > limit) begin
        st = ST_MESSAGE_BIG;
      end else if (ph == PH_BODY) begin
        body = 1'b1;
        st   = (count_nxt >= expect_nxt) ? ST_COMPLETE : ST_BODY;
      end else begin
        // Terminator tracking.
        if (in_data_byte == CH_CR) begin
          term_nxt = (tm == 2'd2) ? 2'd3 : 2'd1;
        end else if (in_data_byte == CH_LF) begin
          found    = (tm == 2'd3);
          term_nxt = (tm == 2'd1) ? 2'd2 : 2'd0;
        end else begin
          term_nxt = 2'd0;
        end

        if ((in_data_byte == CH_LF) && pend) begin
          if (found) begin
            if ((ph == PH_HDR_NONE) && (perr_nxt == ERR_NONE)) begin
              perr_nxt = ST_BAD_START;
            end
          end else if (at_start) begin
            phase_nxt = PH_HDR_NONE;
            line_nxt  = LINE_CLEAR;
          end else begin
            // End of a header line.
            if (ln.field == LF_NAME) begin
              if (perr_nxt == ERR_NONE) perr_nxt = ST_BAD_LINE;
            end else if (ln.field == LF_LENGTH) begin
              if (ln.digit_seen) begin
                seen_nxt   = 1'b1;
                length_nxt = ln.acc;
              end else if (perr_nxt == ERR_NONE) begin
                perr_nxt = ST_BAD_VALUE;
              end
            end
            phase_nxt = PH_HDR;
            line_nxt  = LINE_CLEAR;
          end
        end else begin
          // A held CR that was not followed by LF is a line character.
          if (pend && !at_start) begin
            if (line_nxt.field == LF_NAME) begin
              line_nxt.name_mismatch = 1'b1;
            end else if ((line_nxt.field == LF_LENGTH) && line_nxt.digit_seen) begin
              line_nxt.trailing = 1'b1;
            end
          end
          if (in_data_byte != CH_CR) begin
            fr       = feed(line_nxt, at_start, seen_nxt, in_data_byte);
            line_nxt = fr.line;
            if ((perr_nxt == ERR_NONE) && (fr.err != ERR_NONE)) begin
              perr_nxt = fr.err;
            end
          end
        end

        // Header end: report faults, then size, then start the body.
        if (found) begin
          if (perr_nxt != ERR_NONE) begin
            st = perr_nxt;
          end else if (length_nxt > 64'(max_body_r)) begin
            st = ST_BODY_BIG;
          end else begin
            esum       = 65'(count_nxt) + 65'(length_nxt);
            bstart_nxt = count_nxt;
            expect_nxt = (esum > 65'(COUNT_MAX)) ? COUNT_MAX : esum[COUNT_WIDTH-1:0];
            phase_nxt  = PH_BODY;
            st = (count_nxt >= expect_nxt) ? ST_COMPLETE : ST_BODY;
          end
        end else if (CMP_W'(count_nxt) > CMP_W'(max_header_r)) begin
          st = ST_HEADER_BIG;
        end else begin
          st = ST_HEADER;
        end
      end
      if (st >= ST_COMPLETE) begin
        phase_nxt  = PH_DONE;
        sticky_nxt = st;
      end
      if (st > ST_COMPLETE) begin
        body = 1'b0;
      end
    end

    // Result fields.
    res.status    = st;
    res.body_byte = body;
    if (bstart_nxt != '0) begin
      res.content_len = (length_nxt > DECL_MAX) ? DECL_MAX[31:0] : length_nxt[31:0];
      res.body_offset = (64'(bstart_nxt) > OFFSET_MAX) ? OFFSET_MAX[20:0] :
                        21'(bstart_nxt);
    end else begin
      res.content_len = 32'd0;
      res.body_offset = 21'd0;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      term_r   <= 2'd0;
      count_r  <= '0;
      line_r   <= LINE_CLEAR;
      seen_r   <= 1'b0;
      length_r <= 64'd0;
      perr_r   <= ERR_NONE;
      expect_r <= '0;
      sticky_r <= ST_HEADER;
      bstart_r <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      term_r   <= term_nxt;
      count_r  <= count_nxt;
      line_r   <= line_nxt;
      seen_r   <= seen_nxt;
      length_r <= length_nxt;
      perr_r   <= perr_nxt;
      expect_r <= expect_nxt;
      sticky_r <= sticky_nxt;
      bstart_r <= bstart_nxt;
    end
  end

  // Result register and stall.
  hmlf_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .full_stall (full_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign out_status      = out_data.status;
  assign out_body_byte   = out_data.body_byte;
  assign out_content_len = out_data.content_len;
  assign out_body_offset = out_data.body_offset;

  // Checks on the framer state and results.
  `HMLF_ASSERT_NOW(a_body_flag, clk, rst_n, out_valid && out_body_byte, (out_status == ST_BODY) || (out_status == ST_COMPLETE), "body flag set outside body status")
  `HMLF_ASSERT_NEXT(a_done_sticky, clk, rst_n, (phase_r == PH_DONE) && !(accept && in_new_message), phase_r == PH_DONE, "finished message left its final state")
  `HMLF_ASSERT_NOW(a_done_status, clk, rst_n, phase_r == PH_DONE, sticky_r >= ST_COMPLETE, "finished message without a final status")
  `HMLF_ASSERT_NOW(a_body_pending, clk, rst_n, phase_r == PH_BODY, count_r < expect_r, "body phase with the declared length reached")

endmodule

`default_nettype wire
